FILE: hw/rtl/depq_pkg.sv
// ----------------------------------------------------------------------------
// depq_pkg: shared definitions for the double-ended priority queue
// Action and status codes seen at the ports, and the control word that the
// sequencer broadcasts to every cell of the sorted array.
// ----------------------------------------------------------------------------
package depq_pkg;

   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP_MAX = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_MIN = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/depq_cell.sv
// ----------------------------------------------------------------------------
// depq_cell: one slot of the sorted array
// Holds one entry, compares it with the broadcast item, and on command
// keeps its entry, takes the item, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module depq_cell #(
   parameter int unsigned IDX      = 0,
   parameter int unsigned ENTRY_W  = 48,
   parameter int unsigned KEY_BITS = 24,
   parameter int unsigned CNT_W    = 7
) (
   input  logic                    clock,
   input  depq_pkg::cell_ctrl_type ctrl,
   input  logic [ENTRY_W-1:0]      item,
   input  logic [CNT_W-1:0]        count,
   input  logic [ENTRY_W-1:0]      left_entry,
   input  logic                    left_ge,
   input  logic [ENTRY_W-1:0]      right_entry,
   output logic [ENTRY_W-1:0]      entry_out,
   output logic                    ge_out,
   output logic                    eq_out,
   output logic [KEY_BITS-1:0]     tail_key_out
);

   logic [ENTRY_W-1:0]  entry_ff, entry_in;
   logic                ge_ff, eq_ff;
   logic [KEY_BITS-1:0] tail_key_ff;
   logic                occupied;
   logic                is_tail;

   assign occupied = count > CNT_W'(IDX);
   assign is_tail  = count == CNT_W'(IDX + 1);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         depq_pkg::CELL_INSERT: begin
            // Cells at or above the insertion point move up by one slot; the
            // first of them takes the new item.
            if (ge_ff) begin
               entry_in = left_ge ? left_entry : item;
            end
         end
         depq_pkg::CELL_SHIFT_DOWN: entry_in = right_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.op == depq_pkg::CELL_COMPARE) begin
         // An empty slot counts as larger than any item.
         ge_ff       <= !occupied || (entry_ff >= item);
         eq_ff       <= occupied && (entry_ff == item);
         tail_key_ff <= is_tail ? entry_ff[KEY_BITS-1:0] : '0;
      end
   end

   assign entry_out    = entry_ff;
   assign ge_out       = ge_ff;
   assign eq_out       = eq_ff;
   assign tail_key_out = tail_key_ff;

endmodule

FILE: hw/rtl/double_ended_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit: bounded set of (priority, key) entries
// Insert, pop-max and pop-min over a sorted row of cells, smallest entry in
// cell 0. Duplicate inserts are ignored; full and empty cases are reported.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                      Handshake
//   request   req_action, req_client_key, req_priority_req  start & !busy
//   response  rsp_removed_key, rsp_status                rsp_strobe, one cycle
//
// Each transaction passes through accept, a compare cycle in which every cell
// compares its entry with the item, and an apply cycle in which the cells
// shift. In the cycle after apply, pops and full inserts raise the strobe
// (other inserts give none) and a new request can be accepted. Busy is high
// in compare and apply. Reset empties the store. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit #(
   parameter int unsigned CAPACITY  = 64,
   parameter int unsigned KEY_BITS  = 24,
   parameter int unsigned PRIO_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [depq_pkg::ACTION_W-1:0] req_action,
   input  logic [KEY_BITS-1:0]           req_client_key,
   input  logic [PRIO_BITS-1:0]          req_priority_req,
   output logic                          rsp_strobe,
   output logic [KEY_BITS-1:0]           rsp_removed_key,
   output logic [depq_pkg::STATUS_W-1:0] rsp_status
);

   localparam int unsigned ENTRY_W = KEY_BITS + PRIO_BITS;
   localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY
   } state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [ENTRY_W-1:0]            item_ff;
   logic [depq_pkg::ACTION_W-1:0] action_ff;
   logic                          strobe_ff;
   logic [KEY_BITS-1:0]           key_ff;
   logic [depq_pkg::STATUS_W-1:0] status_ff;

   depq_pkg::cell_ctrl_type ctrl;
   logic [ENTRY_W-1:0]      entry_vec [CAPACITY];
   logic [KEY_BITS-1:0]     tail_vec  [CAPACITY];
   logic [CAPACITY-1:0]     ge_vec;
   logic [CAPACITY-1:0]     eq_vec;
   logic                    duplicate;
   logic                    full;
   logic                    empty;
   logic [KEY_BITS-1:0]     max_key;

   assign duplicate = |eq_vec;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign empty     = count_ff == '0;

   // Only the last occupied cell presents a nonzero tail key.
   always_comb begin
      max_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         max_key = max_key | tail_vec[i];
      end
   end

   always_comb begin
      ctrl.op = depq_pkg::CELL_HOLD;
      unique case (state_ff)
         S_COMPARE: ctrl.op = depq_pkg::CELL_COMPARE;
         S_APPLY: begin
            if (action_ff == depq_pkg::ACT_INSERT && !duplicate && !full) begin
               ctrl.op = depq_pkg::CELL_INSERT;
            end else if (action_ff == depq_pkg::ACT_POP_MIN && !empty) begin
               ctrl.op = depq_pkg::CELL_SHIFT_DOWN;
            end
         end
         default: ctrl.op = depq_pkg::CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ENTRY_W-1:0] left_entry;
      logic [ENTRY_W-1:0] right_entry;
      logic               left_ge;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_ge    = 1'b0;
      end else begin : g_inner
         assign left_entry = entry_vec[i-1];
         assign left_ge    = ge_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_lower
         assign right_entry = entry_vec[i+1];
      end

      depq_cell #(
         .IDX      (i),
         .ENTRY_W  (ENTRY_W),
         .KEY_BITS (KEY_BITS),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .item         (item_ff),
         .count        (count_ff),
         .left_entry   (left_entry),
         .left_ge      (left_ge),
         .right_entry  (right_entry),
         .entry_out    (entry_vec[i]),
         .ge_out       (ge_vec[i]),
         .eq_out       (eq_vec[i]),
         .tail_key_out (tail_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  item_ff   <= {req_priority_req, req_client_key};
                  action_ff <= req_action;
                  state_ff  <= S_COMPARE;
               end
            end
            S_COMPARE: state_ff <= S_APPLY;
            S_APPLY: begin
               state_ff <= S_IDLE;
               unique case (action_ff) inside
                  depq_pkg::ACT_INSERT: begin
                     if (!duplicate) begin
                        if (full) begin
                           strobe_ff <= 1'b1;
                           key_ff    <= '0;
                           status_ff <= depq_pkg::ST_FULL;
                        end else begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                  end
                  depq_pkg::ACT_POP_MAX, depq_pkg::ACT_POP_MIN: begin
                     strobe_ff <= 1'b1;
                     if (empty) begin
                        key_ff    <= '0;
                        status_ff <= depq_pkg::ST_EMPTY;
                     end else begin
                        key_ff    <= (action_ff == depq_pkg::ACT_POP_MAX) ? max_key
                                     : entry_vec[0][KEY_BITS-1:0];
                        status_ff <= depq_pkg::ST_OK;
                        count_ff  <= count_ff - CNT_W'(1);
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_strobe      = strobe_ff;
   assign rsp_removed_key = key_ff;
   assign rsp_status      = status_ff;

endmodule

FILE: hw/rtl/depq_checker.sv
// ----------------------------------------------------------------------------
// depq_checker: port-level checks for the priority queue unit
// Watches the request and response ports and flags illegal sequences.
// ----------------------------------------------------------------------------
module depq_checker #(
   parameter int unsigned KEY_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [KEY_BITS-1:0]           rsp_removed_key,
   input logic [depq_pkg::STATUS_W-1:0] rsp_status
);

   // An accepted transaction keeps the unit busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a transaction");

   // A response only follows a cycle of work.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");

   // At most one response per transaction, so strobes never come back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // Failure responses carry a zero key.
   a_fail_zero_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != depq_pkg::ST_OK) |-> rsp_removed_key == '0)
      else $error("nonzero key on an empty or full response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == depq_pkg::ST_OK ||
                      rsp_status == depq_pkg::ST_EMPTY ||
                      rsp_status == depq_pkg::ST_FULL))
      else $error("undefined response status");

endmodule

bind double_ended_priority_queue_unit depq_checker #(
   .KEY_BITS (KEY_BITS)
) u_depq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_removed_key (rsp_removed_key),
   .rsp_status      (rsp_status)
);
